// ===== sv/ps2dec_pkg.sv =====
// Shared types, constants and US-layout character tables for the scan code decoder.
package ps2dec_pkg;

    localparam int CODE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int TABLE_LEN = 59;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Special scan code values of set 1.
    localparam code_t PREFIX_EXT  = 8'hE0;
    localparam code_t LSHIFT      = 8'h2A;
    localparam code_t RSHIFT      = 8'h36;
    localparam int    RELEASE_BIT = 7;

    // Decode outcome for one request, plus the flags it leaves behind.
    typedef struct packed {
        logic  emit;
        char_t ch;
        logic  shift_held;
        logic  skip_next;
    } decode_t;

    // Load request toward the output register.
    typedef struct packed {
        logic  load;
        char_t ch;
    } out_req_t;

    // Unshifted US layout, indexed by make code.
    localparam char_t PLAIN_TAB [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
        7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Shifted US layout, indexed by make code.
    localparam char_t SHIFT_TAB [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
        7'h5F, 7'h2B, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
        7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

endpackage

// ===== sv/ps2dec_decode.sv =====
// Combinational decode of one registered scan code against the shift and prefix flags.
module ps2dec_decode (
    input  ps2dec_pkg::code_t   code,
    input  logic                shift_held,
    input  logic                skip_next,
    output ps2dec_pkg::decode_t dec
);
    import ps2dec_pkg::*;

    logic [IDX_W-1:0] idx;
    char_t            plain_ch;
    char_t            shift_ch;

    // Table lookups; only meaningful when the code is below the table length.
    assign idx      = code[IDX_W-1:0];
    assign plain_ch = PLAIN_TAB[idx];
    assign shift_ch = SHIFT_TAB[idx];

    // Skip after prefix, prefix, release, shift make and table cases in priority order.
    always_comb
    begin
        dec.emit       = 1'b0;
        dec.ch         = shift_held ? shift_ch : plain_ch;
        dec.shift_held = shift_held;
        dec.skip_next  = 1'b0;
        if (skip_next)
        begin
            dec.skip_next = 1'b0;
        end
        else if (code == PREFIX_EXT)
        begin
            dec.skip_next = 1'b1;
        end
        else if (code[RELEASE_BIT])
        begin
            if ({1'b0, code[RELEASE_BIT-1:0]} inside {LSHIFT, RSHIFT})
            begin
                dec.shift_held = 1'b0;
            end
        end
        else if (code inside {LSHIFT, RSHIFT})
        begin
            dec.shift_held = 1'b1;
        end
        else if (code < code_t'(TABLE_LEN))
        begin
            dec.emit = (dec.ch != '0);
        end
    end

endmodule

// ===== sv/ps2dec_out_reg.sv =====
// Output register that holds a decoded character until the receiver takes it.
module ps2dec_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ps2dec_pkg::out_req_t req,
    input  logic                 out_stall,
    output logic                 out_valid,
    output ps2dec_pkg::char_t    ascii_char,
    output logic                 ready
);
    import ps2dec_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    char_t char_reg;

    // The register can take a new character when empty or when its content leaves now.
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Character payload loads only with a request.
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            char_reg <= req.ch;
        end
    end

    assign out_valid  = valid_reg;
    assign ascii_char = char_reg;

endmodule

// ===== sv/ps2_scancode_to_ascii_decoder.sv =====
// Top level of the PS/2 set 1 scan code to US-layout ASCII decoder.
//
// Input channel: in_valid, in_stall, scancode. One raw scan code byte is
// taken per request at a clock edge where in_valid is high and in_stall low.
// Output channel: out_valid, out_stall, ascii_char. A request yields zero or
// one character; prefix bytes, the byte after a prefix, releases, shift makes
// and unmapped codes yield none.
// A character passes the input register and the decode into the output
// register, where it shows on out_valid; the receiver can take it at the
// following edge. Throughput: one scan code per cycle while in_stall is
// low, set by the single decode stage that sits between the input register
// and the output register.
// When the receiver stalls, the character holds in the output register and
// the next scan code waits in the input register; in_stall rises only when
// that waiting code must also produce a character. Codes that produce no
// character keep flowing past a stalled output.
// Reset clears the shift and prefix flags and both valid bits.
module ps2_scancode_to_ascii_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ps2dec_pkg::code_t   scancode,
    output logic                out_valid,
    input  logic                out_stall,
    output ps2dec_pkg::char_t   ascii_char
);
    import ps2dec_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    code_t    code_reg;
    logic     shift_held_reg;
    logic     shift_held_next;
    logic     skip_next_reg;
    logic     skip_next_next;
    logic     accept;
    logic     advance;
    logic     out_ready;
    decode_t  dec;
    out_req_t out_req;

    // Decode the registered scan code.
    ps2dec_decode u_decode (
        .code       (code_reg),
        .shift_held (shift_held_reg),
        .skip_next  (skip_next_reg),
        .dec        (dec)
    );

    // The registered code leaves when it emits nothing or the output can take it.
    assign advance  = s1_valid_reg && (!dec.emit || out_ready);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_req.load = advance && dec.emit;
    assign out_req.ch   = dec.ch;

    ps2dec_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (out_req),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ascii_char (ascii_char),
        .ready      (out_ready)
    );

    // Input stage occupancy and flag updates.
    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        shift_held_next = shift_held_reg;
        skip_next_next  = skip_next_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            shift_held_next = dec.shift_held;
            skip_next_next  = dec.skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            shift_held_reg <= 1'b0;
            skip_next_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            shift_held_reg <= shift_held_next;
            skip_next_reg  <= skip_next_next;
        end
    end

    // Scan code payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= scancode;
        end
    end

`ifndef SYNTHESIS
    // The byte after a prefix never produces a character.
    a_skip_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance && skip_next_reg |-> !out_req.load)
        else $error("byte after prefix produced a character");

    // A prefix that is not itself skipped arms the skip flag.
    a_prefix_arms_skip: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !skip_next_reg && (code_reg == PREFIX_EXT) |=> skip_next_reg)
        else $error("prefix did not arm skip flag");

    // Stall toward the sender only while a code waits in the input register.
    a_stall_needs_code: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && dec.emit)
        else $error("input stalled without a waiting character");

    // A delivered character is never zero.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char != '0))
        else $error("zero character presented");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the PS/2 set 1 scan code to ASCII decoder.
module tb_top;

    import ps2dec_pkg::*;

    localparam int    MAX_GAP      = 13;
    localparam int    RANDOM_ITEMS = 1950;
    localparam int    DRAIN_CYCLES = 16;
    localparam code_t RELEASE_MASK = 8'h80;

    // Expected characters for the unshifted US layout, indexed by make code.
    localparam char_t KEY_PLAIN [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Expected characters for the shifted US layout, indexed by make code.
    localparam char_t KEY_SHIFTED [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Tracks the keyboard flags and holds the characters still to arrive.
    class char_tracker;
        bit    shift_held;
        bit    skip_next;
        char_t pending_chars[$];
        int    errors;

        // Decode one accepted scan code and queue the character it yields.
        function void note_code(code_t code);
            char_t ch;
            if (skip_next) begin
                skip_next = 1'b0;
                return;
            end
            if (code == PREFIX_EXT) begin
                skip_next = 1'b1;
                return;
            end
            if (code[RELEASE_BIT]) begin
                if ((code & ~RELEASE_MASK) == LSHIFT || (code & ~RELEASE_MASK) == RSHIFT)
                    shift_held = 1'b0;
                return;
            end
            if (code == LSHIFT || code == RSHIFT) begin
                shift_held = 1'b1;
                return;
            end
            if (code >= TABLE_LEN)
                return;
            ch = shift_held ? KEY_SHIFTED[code] : KEY_PLAIN[code];
            if (ch != '0)
                pending_chars.push_back(ch);
        endfunction

        // Compare one accepted character with the oldest expected one.
        function void check_char(char_t got);
            char_t want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (got !== want) begin
                $display("%0t: ascii_char mismatch: expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    code_t scancode;
    logic  out_valid;
    logic  out_stall;
    char_t ascii_char;

    char_tracker tracker = new();
    bit          quiet;
    int          codes_sent;

    ps2_scancode_to_ascii_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .scancode   (scancode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char)
    );

    always #4 clk = ~clk;

    // Draw an idle count, or none during a quiet stretch.
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one scan code and hold it until the request is taken.
    task automatic send_code(input code_t code);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        scancode <= code;
        do @(posedge clk); while (in_stall);
        tracker.note_code(code);
        codes_sent++;
    endtask

    // Type one key, sometimes with a shift key held around it.
    task automatic send_keystroke();
        code_t key;
        code_t shift_key;
        bit    with_shift;
        with_shift = 1'($urandom_range(0, 1));
        shift_key  = $urandom_range(0, 1) ? LSHIFT : RSHIFT;
        key        = code_t'($urandom_range(0, TABLE_LEN - 1));
        if (with_shift)
            send_code(shift_key);
        send_code(key);
        send_code(key | RELEASE_MASK);
        if (with_shift && $urandom_range(0, 3) != 0)
            send_code(shift_key | RELEASE_MASK);
    endtask

    // Receiver side: idle at random, then take the next character.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            gap = draw_gap();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            tracker.check_char(ascii_char);
        end
    end

    // Sender side: reset, directed codes, random typing, then drain.
    initial
    begin
        code_t directed[$];
        int    kind;
        directed = '{
            8'h00, 8'h02, 8'h0E, 8'h1C, 8'h39, 8'h3A, 8'h3B, 8'h7F,
            LSHIFT, 8'h10, 8'h02, LSHIFT | RELEASE_MASK, 8'h10,
            RSHIFT, 8'h35, RSHIFT | RELEASE_MASK, 8'h35, 8'h9E,
            PREFIX_EXT, LSHIFT, 8'h10,
            PREFIX_EXT, PREFIX_EXT, 8'h1E, 8'hFF, 8'h80
        };
        quiet      = 1'b0;
        codes_sent = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        scancode   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_code(directed[i]);

        // Random part: mostly well-formed typing, some prefixes and noise.
        codes_sent = 0;
        while (codes_sent < RANDOM_ITEMS)
        begin
            quiet = ((codes_sent / 200) % 3 == 1);
            kind  = $urandom_range(0, 9);
            if (kind <= 5)
                send_keystroke();
            else if (kind <= 7)
            begin
                send_code(PREFIX_EXT);
                send_code(code_t'($urandom_range(0, 255)));
            end
            else
                send_code(code_t'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (tracker.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
